@@ rtl/mdtp_pkg.sv @@
// Package for the dataset record parser: sizes, record type codes and shared types.
// Used by the output channel interface and by meshcop_dataset_tlv_parser_unit.
package mdtp_pkg;

  // Dataset and storage sizes.
  localparam int MaxBytes   = 256;
  localparam int NameBytes  = 16;
  localparam int PendBytes  = 16;
  localparam int CntW       = $clog2(MaxBytes + 2);
  localparam int PendIdxW   = $clog2(PendBytes);
  localparam int NameLenW   = 5;

  // Record type codes.
  localparam logic [7:0] TypeChannel = 8'd0;
  localparam logic [7:0] TypePanId   = 8'd1;
  localparam logic [7:0] TypeExtPan  = 8'd2;
  localparam logic [7:0] TypeName    = 8'd3;

  // Length rules for the fixed records.
  localparam logic [7:0] ChannelMinLen = 8'd3;
  localparam logic [7:0] PanMinLen     = 8'd2;
  localparam logic [7:0] ExtPanLen     = 8'd8;

  // Status codes.
  localparam logic StatusOk      = 1'b0;
  localparam logic StatusTooLong = 1'b1;

  // Parser phase within a record.
  typedef enum logic [1:0] {
    PhType,
    PhLen,
    PhValue
  } phase_e;

  // One result word.
  typedef struct packed {
    logic        status;
    logic        channel_found;
    logic [15:0] channel_number;
    logic        pan_found;
    logic [15:0] pan_id;
    logic        ext_pan_found;
    logic [63:0] ext_pan_id;
    logic        name_found;
    logic [NameLenW-1:0] name_length;
    logic [63:0] name_first_half;
    logic [63:0] name_second_half;
  } result_t;

endpackage

@@ rtl/mdtp_in_if.sv @@
// Input channel carrying one dataset byte per word with a last-byte mark.
// Depends on nothing but the valid/ready handshake.
interface mdtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ rtl/mdtp_out_if.sv @@
// Output channel carrying one parse result word per dataset.
// Depends on mdtp_pkg for the name length width.
interface mdtp_out_if;
  import mdtp_pkg::*;

  logic                valid;
  logic                ready;
  logic                status;
  logic                channel_found;
  logic [15:0]         channel_number;
  logic                pan_found;
  logic [15:0]         pan_id;
  logic                ext_pan_found;
  logic [63:0]         ext_pan_id;
  logic                name_found;
  logic [NameLenW-1:0] name_length;
  logic [63:0]         name_first_half;
  logic [63:0]         name_second_half;

  modport source (output valid, input ready, output status, output channel_found,
                  output channel_number, output pan_found, output pan_id,
                  output ext_pan_found, output ext_pan_id, output name_found,
                  output name_length, output name_first_half, output name_second_half);
  modport sink   (input valid, output ready, input status, input channel_found,
                  input channel_number, input pan_found, input pan_id,
                  input ext_pan_found, input ext_pan_id, input name_found,
                  input name_length, input name_first_half, input name_second_half);
endinterface

@@ rtl/meshcop_dataset_tlv_parser_unit.sv @@
// Streaming dataset record parser: one byte per cycle when not stalled, one result word per dataset.
// The result word for a dataset is written to the result register once its last byte is processed.
// The input register, the parse/commit logic and the result register form a two-stage
// pipeline that takes one byte per cycle and only stalls when the result register is
// still full while a last byte waits to be processed.
// Reset (rst_ni low) clears the parse state, all committed fields and both valid flags.
module meshcop_dataset_tlv_parser_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  mdtp_in_if.sink       in_i,
  mdtp_out_if.source    out_o
);
  import mdtp_pkg::*;

  // Input register stage.
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       s1_fire;
  logic       out_free;

  // Parse state.
  phase_e              phase_q, phase_d;
  logic [7:0]          type_q, type_d;
  logic [7:0]          len_q, len_d;
  logic [7:0]          idx_q, idx_d;
  logic [CntW-1:0]     bc_q, bc_d;
  logic [PendBytes-1:0][7:0] pend_q, pend_d;

  // Committed fields.
  logic                chan_found_q, chan_found_d;
  logic [15:0]         chan_q, chan_d;
  logic                pan_found_q, pan_found_d;
  logic [15:0]         pan_q, pan_d;
  logic                ext_found_q, ext_found_d;
  logic [63:0]         ext_q, ext_d;
  logic                name_found_q, name_found_d;
  logic [NameLenW-1:0] name_len_q, name_len_d;
  logic [PendBytes-1:0][7:0] name_q, name_d;

  // Result register.
  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;

  // Scratch for the commit logic.
  logic                commit;
  logic [7:0]          rec_len;
  logic [7:0]          idx_inc;
  logic [NameLenW-1:0] new_len;

  assign out_free = !out_valid_q || out_o.ready;
  // A last byte may only be processed when the result register can take its word.
  assign s1_fire  = s1_valid_q && (!s1_last_q || out_free);
  assign in_i.ready = !s1_valid_q || s1_fire;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.data_byte;
      s1_last_q <= in_i.last_byte;
    end
  end

  // Parse, commit and result formation for the registered byte.
  always_comb begin
    phase_d      = phase_q;
    type_d       = type_q;
    len_d        = len_q;
    idx_d        = idx_q;
    bc_d         = bc_q;
    pend_d       = pend_q;
    chan_found_d = chan_found_q;
    chan_d       = chan_q;
    pan_found_d  = pan_found_q;
    pan_d        = pan_q;
    ext_found_d  = ext_found_q;
    ext_d        = ext_q;
    name_found_d = name_found_q;
    name_len_d   = name_len_q;
    name_d       = name_q;
    res_d        = res_q;
    commit       = 1'b0;
    rec_len      = len_q;
    idx_inc      = idx_q + 8'd1;
    new_len      = '0;

    if (s1_fire) begin
      // Byte counter saturates one past the maximum.
      if (bc_q <= CntW'(MaxBytes)) begin
        bc_d = bc_q + CntW'(1);
      end

      case (phase_q)
        PhType: begin
          type_d  = s1_byte_q;
          phase_d = PhLen;
        end
        PhLen: begin
          len_d   = s1_byte_q;
          rec_len = s1_byte_q;
          idx_d   = '0;
          pend_d  = '0;
          if (s1_byte_q == 8'd0) begin
            commit = 1'b1;
          end else begin
            phase_d = PhValue;
          end
        end
        PhValue: begin
          if (idx_q < 8'(PendBytes)) begin
            pend_d[idx_q[PendIdxW-1:0]] = s1_byte_q;
          end
          idx_d = idx_inc;
          if (idx_inc >= len_q) begin
            commit = 1'b1;
          end
        end
        default: begin
          phase_d = PhType;
        end
      endcase

      // Commit a finished record into the field it describes.
      if (commit) begin
        phase_d = PhType;
        case (type_q)
          TypeChannel: begin
            if (rec_len >= ChannelMinLen) begin
              chan_d       = {pend_d[1], pend_d[2]};
              chan_found_d = 1'b1;
            end
          end
          TypePanId: begin
            if (rec_len >= PanMinLen) begin
              pan_d       = {pend_d[0], pend_d[1]};
              pan_found_d = 1'b1;
            end
          end
          TypeExtPan: begin
            if (rec_len == ExtPanLen) begin
              for (int i = 0; i < 8; i++) begin
                ext_d[63 - 8*i -: 8] = pend_d[i];
              end
              ext_found_d = 1'b1;
            end
          end
          TypeName: begin
            new_len = (rec_len < 8'(NameBytes)) ? rec_len[NameLenW-1:0]
                                                : NameLenW'(NameBytes);
            for (int i = 0; i < PendBytes; i++) begin
              name_d[i] = (NameLenW'(i) < new_len) ? pend_d[i] : 8'd0;
            end
            name_len_d   = new_len;
            name_found_d = 1'b1;
          end
          default: begin
          end
        endcase
      end

      // End of dataset: form the result word and return to the reset state.
      if (s1_last_q) begin
        res_d = '0;
        if (bc_d > CntW'(MaxBytes)) begin
          res_d.status = StatusTooLong;
        end else begin
          res_d.status         = StatusOk;
          res_d.channel_found  = chan_found_d;
          res_d.channel_number = chan_found_d ? chan_d : 16'd0;
          res_d.pan_found      = pan_found_d;
          res_d.pan_id         = pan_found_d ? pan_d : 16'd0;
          res_d.ext_pan_found  = ext_found_d;
          res_d.ext_pan_id     = ext_found_d ? ext_d : 64'd0;
          res_d.name_found     = name_found_d;
          res_d.name_length    = name_found_d ? name_len_d : '0;
          for (int i = 0; i < 8; i++) begin
            res_d.name_first_half[63 - 8*i -: 8]  = name_found_d ? name_d[i] : 8'd0;
            res_d.name_second_half[63 - 8*i -: 8] = name_found_d ? name_d[i+8] : 8'd0;
          end
        end
        phase_d      = PhType;
        type_d       = '0;
        len_d        = '0;
        idx_d        = '0;
        bc_d         = '0;
        pend_d       = '0;
        chan_found_d = 1'b0;
        chan_d       = '0;
        pan_found_d  = 1'b0;
        pan_d        = '0;
        ext_found_d  = 1'b0;
        ext_d        = '0;
        name_found_d = 1'b0;
        name_len_d   = '0;
        name_d       = '0;
      end
    end
  end

  // Result valid flag: set by a processed last byte, cleared when the word is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && s1_last_q) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhType;
      type_q       <= '0;
      len_q        <= '0;
      idx_q        <= '0;
      bc_q         <= '0;
      pend_q       <= '0;
      chan_found_q <= 1'b0;
      chan_q       <= '0;
      pan_found_q  <= 1'b0;
      pan_q        <= '0;
      ext_found_q  <= 1'b0;
      ext_q        <= '0;
      name_found_q <= 1'b0;
      name_len_q   <= '0;
      name_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      type_q       <= type_d;
      len_q        <= len_d;
      idx_q        <= idx_d;
      bc_q         <= bc_d;
      pend_q       <= pend_d;
      chan_found_q <= chan_found_d;
      chan_q       <= chan_d;
      pan_found_q  <= pan_found_d;
      pan_q        <= pan_d;
      ext_found_q  <= ext_found_d;
      ext_q        <= ext_d;
      name_found_q <= name_found_d;
      name_len_q   <= name_len_d;
      name_q       <= name_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // Output word.
  assign out_o.valid            = out_valid_q;
  assign out_o.status           = res_q.status;
  assign out_o.channel_found    = res_q.channel_found;
  assign out_o.channel_number   = res_q.channel_number;
  assign out_o.pan_found        = res_q.pan_found;
  assign out_o.pan_id           = res_q.pan_id;
  assign out_o.ext_pan_found    = res_q.ext_pan_found;
  assign out_o.ext_pan_id       = res_q.ext_pan_id;
  assign out_o.name_found       = res_q.name_found;
  assign out_o.name_length      = res_q.name_length;
  assign out_o.name_first_half  = res_q.name_first_half;
  assign out_o.name_second_half = res_q.name_second_half;

  // The byte counter never runs past its saturation value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bc_q <= CntW'(MaxBytes + 1))
    else $error("byte counter beyond saturation");

  // After a last byte the parser is back at the start of a record with a clear count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_last_q) |=> (phase_q == PhType && bc_q == '0 && !name_found_q))
    else $error("parser not reset after end of dataset");

  // An overlong dataset reports no fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status == StatusTooLong) |->
      (!res_q.channel_found && !res_q.pan_found && !res_q.ext_pan_found && !res_q.name_found))
    else $error("fields reported for overlong dataset");

  // The reported name length never exceeds the kept name bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.name_length <= NameLenW'(NameBytes)))
    else $error("name length beyond storage");

  // A last byte is never processed while the result register is still held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_last_q) |-> out_free)
    else $error("result word overwritten");

endmodule
